[hw/rtl/cft_pkg.sv]
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Shared constants, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package cft_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [7:0] NewlineByte = 8'h0A;

   localparam logic [7:0] DelimiterReset     = 8'd44;
   localparam logic [7:0] QuoteReset         = 8'd34;
   localparam logic       SkipEmptyReset     = 1'b1;
   localparam logic       FirstIsHeaderReset = 1'b0;

   typedef enum logic [1:0] {
      CSR_DELIMITER       = 2'd0,
      CSR_QUOTE           = 2'd1,
      CSR_SKIP_EMPTY      = 2'd2,
      CSR_FIRST_IS_HEADER = 2'd3
   } csr_index_type;

   localparam logic KindChar     = 1'b0;
   localparam logic KindFieldEnd = 1'b1;

   // One step's results: a first result, optionally followed by a
   // record-ending field end carrying the same header tag.
   typedef struct packed {
      logic       two;
      logic       kind0;
      logic [7:0] char0;
      logic       rec0;
      logic       tag;
   } entry_type;

endpackage

[hw/rtl/cft_front.sv]
// ----------------------------------------------------------------------------
// CSV field tokenizer front end
// Holds the control registers and line state, classifies each byte and
// pushes its results into the queue.
// ----------------------------------------------------------------------------
module cft_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   input  logic               in_valid,
   input  logic [7:0]         in_byte,
   input  logic               in_final,
   input  logic               queue_full,
   output logic               in_ready,
   output logic               push,
   output cft_pkg::entry_type push_entry
);

   logic [7:0] delim_ff, delim_in;
   logic [7:0] quote_ff, quote_in;
   logic       skip_ff, skip_in;
   logic       hdr_en_ff, hdr_en_in;

   logic quoting_ff, quoting_in;
   logic pending_ff, pending_in;
   logic empty_ff, empty_in;
   logic seen_ff, seen_in;

   logic accept;
   logic is_nl, is_quote, is_delim;
   logic consumed, quoting_eff;
   logic first_res;
   logic tag;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   assign is_nl       = (in_byte == cft_pkg::NewlineByte);
   assign is_quote    = (in_byte == quote_ff);
   assign is_delim    = (in_byte == delim_ff);
   assign consumed    = pending_ff && is_quote;
   assign quoting_eff = pending_ff ? 1'b0 : quoting_ff;
   assign tag         = hdr_en_ff && !seen_ff;

   always_comb begin
      delim_in  = delim_ff;
      quote_in  = quote_ff;
      skip_in   = skip_ff;
      hdr_en_in = hdr_en_ff;
      if (csr_we) begin
         case (csr_index)
            cft_pkg::CSR_DELIMITER:       delim_in  = csr_wdata;
            cft_pkg::CSR_QUOTE:           quote_in  = csr_wdata;
            cft_pkg::CSR_SKIP_EMPTY:      skip_in   = csr_wdata[0];
            cft_pkg::CSR_FIRST_IS_HEADER: hdr_en_in = csr_wdata[0];
            default:                      delim_in  = delim_ff;
         endcase
      end
   end

   always_comb begin
      quoting_in = quoting_ff;
      pending_in = pending_ff;
      empty_in   = empty_ff;
      seen_in    = seen_ff;
      first_res  = 1'b0;
      push_entry.two   = 1'b0;
      push_entry.kind0 = cft_pkg::KindFieldEnd;
      push_entry.char0 = 8'd0;
      push_entry.rec0  = 1'b1;
      push_entry.tag   = tag;
      push = 1'b0;

      if (is_nl) begin
         if (!empty_ff || !skip_ff) begin
            first_res = 1'b1;
            seen_in   = 1'b1;
         end
         quoting_in = 1'b0;
         pending_in = 1'b0;
         empty_in   = 1'b1;
      end else begin
         empty_in   = 1'b0;
         pending_in = 1'b0;
         quoting_in = quoting_eff;
         if (consumed) begin
            first_res        = 1'b1;
            push_entry.kind0 = cft_pkg::KindChar;
            push_entry.char0 = in_byte;
            push_entry.rec0  = 1'b0;
            quoting_in       = quoting_ff;
         end else if (is_quote) begin
            if (quoting_eff) begin
               quoting_in = !in_final;
               pending_in = !in_final;
            end else begin
               quoting_in = 1'b1;
            end
         end else if (is_delim && !quoting_eff) begin
            first_res       = 1'b1;
            push_entry.rec0 = 1'b0;
         end else begin
            first_res        = 1'b1;
            push_entry.kind0 = cft_pkg::KindChar;
            push_entry.char0 = in_byte;
            push_entry.rec0  = 1'b0;
         end
         // final byte closes the line with a record end
         if (in_final) begin
            push_entry.two = first_res;
         end
      end

      if (in_final) begin
         quoting_in = 1'b0;
         pending_in = 1'b0;
         empty_in   = 1'b1;
         seen_in    = 1'b0;
      end

      push = accept && (first_res || (in_final && !is_nl));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff   <= cft_pkg::DelimiterReset;
         quote_ff   <= cft_pkg::QuoteReset;
         skip_ff    <= cft_pkg::SkipEmptyReset;
         hdr_en_ff  <= cft_pkg::FirstIsHeaderReset;
         quoting_ff <= 1'b0;
         pending_ff <= 1'b0;
         empty_ff   <= 1'b1;
         seen_ff    <= 1'b0;
      end else begin
         delim_ff  <= delim_in;
         quote_ff  <= quote_in;
         skip_ff   <= skip_in;
         hdr_en_ff <= hdr_en_in;
         if (accept) begin
            quoting_ff <= quoting_in;
            pending_ff <= pending_in;
            empty_ff   <= empty_in;
            seen_ff    <= seen_in;
         end
      end
   end

   a_pending_in_quotes: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> quoting_ff)
      else $error("quote pending outside quotes");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && in_final) |=> (!quoting_ff && !pending_ff && empty_ff && !seen_ff))
      else $error("line state not cleared after final byte");

   a_two_needs_final: assert property (@(posedge clock) disable iff (reset)
      (push && push_entry.two) |-> in_final)
      else $error("second result without final byte");

endmodule

[hw/rtl/cft_queue.sv]
// ----------------------------------------------------------------------------
// CSV field tokenizer queue
// Short FIFO of step results between front and back ends.
// ----------------------------------------------------------------------------
module cft_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cft_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output cft_pkg::entry_type head
);

   cft_pkg::entry_type slot_ff [cft_pkg::QueueDepth];

   logic [cft_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cft_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cft_pkg::QueueCntW-1:0] count_ff, count_in;

   assign full      = (count_ff == cft_pkg::QueueCntW'(cft_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cft_pkg::QueueCntW'(cft_pkg::QueueDepth))
      else $error("queue count beyond depth");

endmodule

[hw/rtl/cft_back.sv]
// ----------------------------------------------------------------------------
// CSV field tokenizer back end
// Splits queue entries into single results and drives the output register.
// ----------------------------------------------------------------------------
module cft_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  cft_pkg::entry_type head,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               out_kind,
   output logic [7:0]         out_char,
   output logic               out_rec,
   output logic               out_tag,
   output logic               out_last
);

   logic       sel_ff, sel_in;
   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in;
   logic [7:0] char_ff, char_in;
   logic       rec_ff, rec_in;
   logic       tag_ff, tag_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = (!valid_ff || out_ready) && head_valid;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff && !out_ready;
      kind_in  = kind_ff;
      char_in  = char_ff;
      rec_in   = rec_ff;
      tag_in   = tag_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         tag_in   = head.tag;
         if (!sel_ff) begin
            kind_in = head.kind0;
            char_in = head.char0;
            rec_in  = head.rec0;
            last_in = !head.two;
            sel_in  = head.two;
            pop     = !head.two;
         end else begin
            kind_in = cft_pkg::KindFieldEnd;
            char_in = 8'd0;
            rec_in  = 1'b1;
            last_in = 1'b1;
            sel_in  = 1'b0;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      char_ff <= char_in;
      rec_ff  <= rec_in;
      tag_ff  <= tag_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_char  = char_ff;
   assign out_rec   = rec_ff;
   assign out_tag   = tag_ff;
   assign out_last  = last_ff;

   a_sel_holds_entry: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (head_valid && head.two))
      else $error("second result selected without a two-result entry");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (load && !sel_ff && head.two) |=> (sel_ff && valid_ff && !last_ff))
      else $error("first of two results not followed by second");

   a_end_char_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == cft_pkg::KindFieldEnd) |-> (char_ff == 8'd0 || !rec_ff))
      else $error("record end carries a character");

endmodule

[hw/rtl/csv_field_tokenizer.sv]
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Streams CSV text one byte per transfer and emits field characters and
// field-end marks, with record ends and header tagging.
//
//   channel  direction  tdata                       tuser  tlast
//   req      in         text_byte                   -      final_byte
//   rsp      out        char_value, rec, header     kind   run_last
//   csr      in         write enable, index, data (no read-back)
//
// One byte is accepted per cycle while the four-entry queue has room.
// A byte gives zero, one or two results; the back end sends one result per
// cycle while rsp_tready is high, so the rate is one byte per cycle unless
// two-result bytes outpace the output. First result is held in a queue slot,
// then in the output register. Reset is synchronous and restores register
// defaults and line state. Output stalls fill the queue, then drop req_tready.
// ----------------------------------------------------------------------------
module csv_field_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] char_value, [8] record_end, [9] header_tag
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic               push;
   logic               pop;
   logic               full;
   logic               not_empty;
   cft_pkg::entry_type push_entry;
   cft_pkg::entry_type head;
   logic [7:0]         out_char;
   logic               out_rec;
   logic               out_tag;

   cft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_final   (req_tlast),
      .queue_full (full),
      .in_ready   (req_tready),
      .push       (push),
      .push_entry (push_entry)
   );

   cft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   cft_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (rsp_tuser),
      .out_char   (out_char),
      .out_rec    (out_rec),
      .out_tag    (out_tag),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_tag, out_rec, out_char};

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// Streams directed and random CSV content through the tokenizer under random
// stalls on both sides, predicts every field character and field end in a
// scoreboard and checks the result stream token by token.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic       kind;
      logic [7:0] char_value;
      logic       record_end;
      logic       header_tag;
      logic       run_last;
   } token_type;

   class field_scoreboard;
      logic [7:0] delim;
      logic [7:0] quote;
      logic       drop_blank;
      logic       first_hdr;
      logic       quoted;
      logic       quote_held;
      logic       line_blank;
      logic       hdr_seen;
      token_type  expected_tokens[$];
      int unsigned errors;

      function new();
         delim      = cft_pkg::DelimiterReset;
         quote      = cft_pkg::QuoteReset;
         drop_blank = cft_pkg::SkipEmptyReset;
         first_hdr  = cft_pkg::FirstIsHeaderReset;
         hdr_seen   = 1'b0;
         errors     = 0;
         clear_line();
      endfunction

      function void clear_line();
         quoted     = 1'b0;
         quote_held = 1'b0;
         line_blank = 1'b1;
      endfunction

      function void write_reg(cft_pkg::csr_index_type idx, logic [7:0] val);
         case (idx)
            cft_pkg::CSR_DELIMITER:       delim      = val;
            cft_pkg::CSR_QUOTE:           quote      = val;
            cft_pkg::CSR_SKIP_EMPTY:      drop_blank = val[0];
            cft_pkg::CSR_FIRST_IS_HEADER: first_hdr  = val[0];
            default: ;
         endcase
      endfunction

      function token_type make_token(logic kind, logic [7:0] ch, logic rec, logic tag);
         token_type t;
         t.kind       = kind;
         t.char_value = ch;
         t.record_end = rec;
         t.header_tag = tag;
         t.run_last   = 1'b0;
         return t;
      endfunction

      function void note_byte(logic [7:0] b, logic fin);
         token_type out_q[$];
         logic      tag;
         logic      taken;
         tag   = first_hdr && !hdr_seen;
         taken = 1'b0;
         if (b == cft_pkg::NewlineByte) begin
            if (!line_blank || !drop_blank) begin
               out_q.insert(out_q.size(), make_token(cft_pkg::KindFieldEnd, 8'h00, 1'b1, tag));
               hdr_seen = 1'b1;
            end
            clear_line();
         end else begin
            line_blank = 1'b0;
            // a held quote is resolved by the byte after it
            if (quote_held) begin
               quote_held = 1'b0;
               if (b == quote) begin
                  out_q.insert(out_q.size(), make_token(cft_pkg::KindChar, b, 1'b0, tag));
                  taken = 1'b1;
               end else begin
                  quoted = 1'b0;
               end
            end
            if (!taken) begin
               if (b == quote) begin
                  if (quoted) begin
                     if (fin) quoted = 1'b0;
                     else quote_held = 1'b1;
                  end else begin
                     quoted = 1'b1;
                  end
               end else if (b == delim && !quoted) begin
                  out_q.insert(out_q.size(),
                               make_token(cft_pkg::KindFieldEnd, 8'h00, 1'b0, tag));
               end else begin
                  out_q.insert(out_q.size(), make_token(cft_pkg::KindChar, b, 1'b0, tag));
               end
            end
            if (fin) begin
               out_q.insert(out_q.size(), make_token(cft_pkg::KindFieldEnd, 8'h00, 1'b1, tag));
               hdr_seen = 1'b1;
            end
         end
         if (fin) begin
            clear_line();
            hdr_seen = 1'b0;
         end
         if (out_q.size() > 0) out_q[out_q.size() - 1].run_last = 1'b1;
         foreach (out_q[i]) expected_tokens.insert(expected_tokens.size(), out_q[i]);
      endfunction

      function void check_token(token_type got);
         token_type want;
         if (expected_tokens.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: kind=%0d char=%02h rec=%0d tag=%0d last=%0d",
                        got.kind, got.char_value, got.record_end, got.header_tag,
                        got.run_last);
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind || got.char_value !== want.char_value ||
             got.record_end !== want.record_end || got.header_tag !== want.header_tag ||
             got.run_last !== want.run_last) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: expected kind=%0d char=%02h rec=%0d tag=%0d last=%0d",
                        want.kind, want.char_value, want.record_end, want.header_tag,
                        want.run_last);
               $display("          got      kind=%0d char=%02h rec=%0d tag=%0d last=%0d",
                        got.kind, got.char_value, got.record_end, got.header_tag,
                        got.run_last);
            end
         end
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   field_scoreboard sb;
   bit              idle_on;

   csv_field_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b, fin);
   endtask

   task automatic send_str(input string s, input logic fin_at_end);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], fin_at_end && (i == s.len() - 1));
   endtask

   // wait for the result stream to empty, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input cft_pkg::csr_index_type idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == sb.delim || b == sb.quote || b == cft_pkg::NewlineByte);
      return b;
   endfunction

   function automatic logic [7:0] quoted_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == sb.quote || b == cft_pkg::NewlineByte);
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0: return sb.delim;
         1: return sb.quote;
         2: return cft_pkg::NewlineByte;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_reg_byte(input logic [7:0] dflt);
      case ($urandom_range(0, 6))
         0: return 8'h00;
         1: return 8'hFF;
         2: return cft_pkg::NewlineByte;
         3, 4: return 8'($urandom_range(0, 255));
         default: return dflt;
      endcase
   endfunction

   // a few lines of mostly well-formed records, last byte flagged final
   task automatic send_document(inout int unsigned count);
      logic [7:0]  doc[$];
      int unsigned lines;
      int unsigned nf;
      int unsigned r;
      lines = $urandom_range(1, 4);
      for (int l = 0; l < lines; l++) begin
         r = $urandom_range(0, 9);
         if (r == 1) begin
            repeat ($urandom_range(1, 6)) doc.insert(doc.size(), noise_byte());
         end else if (r != 0) begin
            nf = $urandom_range(1, 4);
            for (int f = 0; f < nf; f++) begin
               if (f > 0) doc.insert(doc.size(), sb.delim);
               if ($urandom_range(0, 2) == 0) begin
                  doc.insert(doc.size(), sb.quote);
                  repeat ($urandom_range(0, 4)) begin
                     if ($urandom_range(0, 4) == 0) begin
                        doc.insert(doc.size(), sb.quote);
                        doc.insert(doc.size(), sb.quote);
                     end else begin
                        doc.insert(doc.size(), quoted_char());
                     end
                  end
                  doc.insert(doc.size(), sb.quote);
               end else begin
                  repeat ($urandom_range(0, 4)) doc.insert(doc.size(), plain_char());
               end
            end
         end
         if (l < lines - 1 || $urandom_range(0, 1))
            doc.insert(doc.size(), cft_pkg::NewlineByte);
      end
      if (doc.size() == 0) doc.insert(doc.size(), plain_char());
      foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1);
      count += doc.size();
   endtask

   initial begin
      logic [7:0]  q;
      int unsigned sent;
      sb         = new();
      idle_on    = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = cft_pkg::CSR_DELIMITER;
      csr_wdata  = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_str("a,\"b\"\"c\"\n", 1'b0);
      send_str("\n", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_str("\"q\"", 1'b1);
      send_str("z\n", 1'b1);
      drain();

      // delimiter equal to quote, empty lines kept, header tagging
      write_reg(cft_pkg::CSR_DELIMITER, cft_pkg::QuoteReset);
      write_reg(cft_pkg::CSR_SKIP_EMPTY, 8'h00);
      write_reg(cft_pkg::CSR_FIRST_IS_HEADER, 8'h01);
      send_str("\n\"a\"\"\n", 1'b1);
      drain();

      write_reg(cft_pkg::CSR_DELIMITER, cft_pkg::NewlineByte);
      write_reg(cft_pkg::CSR_QUOTE, cft_pkg::NewlineByte);
      send_str("a\n", 1'b1);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         idle_on = (phase % 4 != 1);
         q = pick_reg_byte(cft_pkg::QuoteReset);
         write_reg(cft_pkg::CSR_QUOTE, q);
         write_reg(cft_pkg::CSR_DELIMITER,
                   ($urandom_range(0, 7) == 0) ? q : pick_reg_byte(cft_pkg::DelimiterReset));
         write_reg(cft_pkg::CSR_SKIP_EMPTY, {7'd0, phase[0]});
         write_reg(cft_pkg::CSR_FIRST_IS_HEADER, {7'd0, phase[1]});
         sent = 0;
         while (sent < 175) send_document(sent);
         // leave a line open so the next settings land mid-line
         if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) send_byte(noise_byte(), 1'b0);
         drain();
      end

      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      token_type   got;
      int unsigned stall;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.kind       = rsp_tuser;
         got.char_value = rsp_tdata[7:0];
         got.record_end = rsp_tdata[8];
         got.header_tag = rsp_tdata[9];
         got.run_last   = rsp_tlast;
         sb.check_token(got);
      end
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/cft_pkg.sv
hw/rtl/cft_front.sv
hw/rtl/cft_queue.sv
hw/rtl/cft_back.sv
hw/rtl/csv_field_tokenizer.sv
sim/testbench.sv
